>>> hdl/tifr_pkg.sv
// Shared types, constants and register map of the tree interval frame router.
`timescale 1ns / 1ps

package tifr_pkg;

  // Largest number of edges a panel can have.
  localparam int MAX_EDGES = 4;
  localparam int EDGES_DEF = 4;

  localparam int EDGE_W   = 2;
  localparam int INDEX_W  = 16;
  localparam int COUNT_W  = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Reset value of the edge count register.
  localparam logic [COUNT_W-1:0] EDGE_COUNT_RST = 3'd4;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_HAS_PARENT     = 3'd0,
    REG_PARENT_EDGE    = 3'd1,
    REG_CONNECTED_MASK = 3'd2,
    REG_EDGE_COUNT     = 3'd3,
    REG_CHILD_INDEX_0  = 3'd4,
    REG_CHILD_INDEX_1  = 3'd5,
    REG_CHILD_INDEX_2  = 3'd6,
    REG_CHILD_INDEX_3  = 3'd7
  } reg_idx_t;

  // Kinds of routing decision.
  typedef enum logic [2:0] {
    KIND_NO_PARENT = 3'd0,
    KIND_UPSTREAM  = 3'd1,
    KIND_ONE_CHILD = 3'd2,
    KIND_FLOOD     = 3'd3,
    KIND_DROPPED   = 3'd4
  } route_kind_t;

  // Frame header as it arrives.
  typedef struct packed {
    logic [EDGE_W-1:0]  from_edge;
    logic [INDEX_W-1:0] target_panel;
  } tifr_in_t;

  // Routing decision as it leaves.
  typedef struct packed {
    logic [MAX_EDGES-1:0] egress_mask;
    route_kind_t          route_kind;
  } tifr_out_t;

  // Scalar topology settings handed from the register block to the decision logic.
  typedef struct packed {
    logic                 has_parent;
    logic [EDGE_W-1:0]    parent_edge;
    logic [MAX_EDGES-1:0] connected_mask;
    logic [COUNT_W-1:0]   edge_count;
  } tifr_topo_t;

endpackage

>>> hdl/tifr_regs.sv
// Configuration register block with its APB-style access port.
`timescale 1ns / 1ps

module tifr_regs #(
  parameter int EDGES = tifr_pkg::EDGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tifr_pkg::ADDR_W-1:0]            paddr,
  input  logic [tifr_pkg::DATA_W-1:0]            pwdata,
  output logic [tifr_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready,
  output tifr_pkg::tifr_topo_t                   topo,
  output logic [EDGES-1:0][tifr_pkg::INDEX_W-1:0] child_idx
);

  tifr_pkg::tifr_topo_t                    topo_r, topo_nxt;
  logic [EDGES-1:0][tifr_pkg::INDEX_W-1:0] child_r, child_nxt;
  tifr_pkg::reg_idx_t                      sel_idx;
  logic                                    wr_en;

  assign pready  = 1'b1;
  assign sel_idx = tifr_pkg::reg_idx_t'(paddr[tifr_pkg::ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Next register values for a completed write transfer.
  always_comb begin
    topo_nxt  = topo_r;
    child_nxt = child_r;
    if (wr_en) begin
      unique case (sel_idx)
        tifr_pkg::REG_HAS_PARENT:     topo_nxt.has_parent     = pwdata[0];
        tifr_pkg::REG_PARENT_EDGE:    topo_nxt.parent_edge    = pwdata[tifr_pkg::EDGE_W-1:0];
        tifr_pkg::REG_CONNECTED_MASK:
          topo_nxt.connected_mask = pwdata[tifr_pkg::MAX_EDGES-1:0];
        tifr_pkg::REG_EDGE_COUNT:     topo_nxt.edge_count     = pwdata[tifr_pkg::COUNT_W-1:0];
        default: begin
          for (int e = 0; e < EDGES; e++) begin
            if (sel_idx == tifr_pkg::reg_idx_t'(tifr_pkg::REG_CHILD_INDEX_0 + e)) begin
              child_nxt[e] = pwdata[tifr_pkg::INDEX_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topo_r.has_parent     <= 1'b0;
      topo_r.parent_edge    <= '0;
      topo_r.connected_mask <= '0;
      topo_r.edge_count     <= tifr_pkg::EDGE_COUNT_RST;
      child_r               <= '0;
    end else begin
      topo_r  <= topo_nxt;
      child_r <= child_nxt;
    end
  end

  // Read data; child indexes beyond the panel's edges read as zero.
  always_comb begin
    prdata = '0;
    unique case (sel_idx)
      tifr_pkg::REG_HAS_PARENT:     prdata[0] = topo_r.has_parent;
      tifr_pkg::REG_PARENT_EDGE:    prdata[tifr_pkg::EDGE_W-1:0] = topo_r.parent_edge;
      tifr_pkg::REG_CONNECTED_MASK: prdata[tifr_pkg::MAX_EDGES-1:0] = topo_r.connected_mask;
      tifr_pkg::REG_EDGE_COUNT:     prdata[tifr_pkg::COUNT_W-1:0] = topo_r.edge_count;
      default: begin
        for (int e = 0; e < EDGES; e++) begin
          if (sel_idx == tifr_pkg::reg_idx_t'(tifr_pkg::REG_CHILD_INDEX_0 + e)) begin
            prdata[tifr_pkg::INDEX_W-1:0] = child_r[e];
          end
        end
      end
    endcase
  end

  assign topo      = topo_r;
  assign child_idx = child_r;

endmodule

>>> hdl/tifr_decide.sv
// Combinational routing decision for one registered frame header.
`timescale 1ns / 1ps

module tifr_decide #(
  parameter int EDGES = tifr_pkg::EDGES_DEF
) (
  input  tifr_pkg::tifr_topo_t                   topo,
  input  logic [EDGES-1:0][tifr_pkg::INDEX_W-1:0] child_idx,
  input  tifr_pkg::tifr_in_t                     hdr,
  output tifr_pkg::tifr_out_t                    res
);

  // Only edges that the panel can have are ever connected.
  localparam logic [tifr_pkg::MAX_EDGES-1:0] LIVE = tifr_pkg::MAX_EDGES'((1 << EDGES) - 1);

  logic [tifr_pkg::MAX_EDGES-1:0] conn;
  logic [tifr_pkg::MAX_EDGES-1:0] flood;
  logic [tifr_pkg::MAX_EDGES-1:0] best_mask;
  logic [tifr_pkg::INDEX_W-1:0]   best_idx;
  logic                           all_known;

  assign conn = topo.connected_mask & LIVE;

  // Flood set: connected edges inside the edge count, except the arrival edge.
  always_comb begin
    flood = '0;
    for (int e = 0; e < EDGES; e++) begin
      flood[e] = (tifr_pkg::COUNT_W'(e) < topo.edge_count) &&
                 (hdr.from_edge != tifr_pkg::EDGE_W'(e)) && conn[e];
    end
  end

  // Child with the largest known index not above the target; the lowest edge wins a tie.
  always_comb begin
    best_mask = '0;
    best_idx  = '0;
    all_known = 1'b1;
    for (int e = 0; e < EDGES; e++) begin
      if (flood[e]) begin
        if (child_idx[e] == '0) begin
          all_known = 1'b0;
        end else if (child_idx[e] <= hdr.target_panel && child_idx[e] > best_idx) begin
          best_idx  = child_idx[e];
          best_mask = tifr_pkg::MAX_EDGES'(1) << e;
        end
      end
    end
  end

  // Final decision.
  always_comb begin
    res.egress_mask = '0;
    res.route_kind  = tifr_pkg::KIND_NO_PARENT;
    priority if (!topo.has_parent) begin
      res.route_kind = tifr_pkg::KIND_NO_PARENT;
    end else if (hdr.from_edge != topo.parent_edge) begin
      res.route_kind = tifr_pkg::KIND_UPSTREAM;
      if (conn[topo.parent_edge]) begin
        res.egress_mask = tifr_pkg::MAX_EDGES'(1) << topo.parent_edge;
      end
    end else if (hdr.target_panel != '0 && all_known) begin
      res.egress_mask = best_mask;
      res.route_kind  = (best_mask != '0) ? tifr_pkg::KIND_ONE_CHILD : tifr_pkg::KIND_DROPPED;
    end else begin
      res.egress_mask = flood;
      res.route_kind  = tifr_pkg::KIND_FLOOD;
    end
  end

endmodule

>>> hdl/tree_interval_frame_router.sv
// Top level of the tree interval frame router: header register, decision logic, result register.
`timescale 1ns / 1ps

// Each accepted frame header yields exactly one routing decision, which passes through the header
// register and then the output register before it can be taken. A new header can be taken in every
// cycle while results are taken. The decision is made by a short chain of 16-bit compares, one per
// edge of the panel, and is then held in the output register. The header register is released
// whenever the output register is free or is being emptied, so headers flow back to back while
// results are taken. A stalled result holds up the input only once the header register is
// full as well.
// Configuration writes through the APB-style port are meant for idle periods only.
module tree_interval_frame_router #(
  parameter int EDGES = tifr_pkg::EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tifr_pkg::tifr_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tifr_pkg::tifr_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tifr_pkg::ADDR_W-1:0] paddr,
  input  logic [tifr_pkg::DATA_W-1:0] pwdata,
  output logic [tifr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  tifr_pkg::tifr_topo_t                    topo;
  logic [EDGES-1:0][tifr_pkg::INDEX_W-1:0] child_idx;
  tifr_pkg::tifr_in_t                      hdr_r;
  logic                                    hdr_vld_r, hdr_vld_nxt;
  tifr_pkg::tifr_out_t                     res;
  tifr_pkg::tifr_out_t                     res_r;
  logic                                    res_vld_r, res_vld_nxt;
  logic                                    res_load;
  logic                                    hdr_load;

  tifr_regs #(.EDGES(EDGES)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .topo      (topo),
    .child_idx (child_idx)
  );

  tifr_decide #(.EDGES(EDGES)) u_decide (
    .topo      (topo),
    .child_idx (child_idx),
    .hdr       (hdr_r),
    .res       (res)
  );

  // Pipeline flow: the result register takes a decision when it is empty or being emptied.
  assign res_load    = hdr_vld_r && (!res_vld_r || out_ready);
  assign in_ready    = !hdr_vld_r || res_load;
  assign hdr_load    = in_valid && in_ready;
  assign hdr_vld_nxt = hdr_load || (hdr_vld_r && !res_load);
  assign res_vld_nxt = res_load || (res_vld_r && !out_ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      hdr_vld_r <= hdr_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (hdr_load) begin
      hdr_r <= in_data;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

>>> hdl/tifr_checker.sv
// Port-level checks on the router's result channel, bound to the top level.
`timescale 1ns / 1ps

module tifr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tifr_pkg::tifr_out_t out_data
);

  // A stalled result transfer keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // With no parent, nothing is sent.
  a_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.route_kind == tifr_pkg::KIND_NO_PARENT |-> out_data.egress_mask == '0)
    else $error("edges sent without a parent");

  // A dropped frame is sent nowhere.
  a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.route_kind == tifr_pkg::KIND_DROPPED |-> out_data.egress_mask == '0)
    else $error("dropped frame sent on an edge");

  // An addressed frame goes to exactly one child.
  a_one_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.route_kind == tifr_pkg::KIND_ONE_CHILD |-> $onehot(out_data.egress_mask))
    else $error("child route not on exactly one edge");

  // The upstream path uses at most the parent edge.
  a_upstream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.route_kind == tifr_pkg::KIND_UPSTREAM |-> $onehot0(out_data.egress_mask))
    else $error("upstream route on more than one edge");

endmodule

bind tree_interval_frame_router tifr_checker u_tifr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
